### design/cct_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the complex coefficient threshold core.
// Used by cct_csub and complex_coefficient_threshold_core; no dependencies.
package cct_pkg;

    // default for the highest degree that is still thresholded
    localparam int MAX_DEGREE_DEF = 4095;

    // width of the shared compare-subtract unit (root and division remainders)
    localparam int W_REM = 34;

    // result of one compare-subtract step
    typedef struct packed {
        logic             ge;
        logic [W_REM-1:0] diff;
    } t_csub_res;

endpackage

### design/complex_coefficient_threshold_core.sv
`timescale 1ns / 1ps
// Complex coefficient threshold core: top level, sequencer and datapath.
// Depends on cct_pkg and cct_csub.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready. s_tdata carries, from bit 0 up,
//   degree (12), re_in (32), im_in (32), zero fill to 80 bits; s_tuser is the
//   first flag, which clears the kept count and maximum degree before the beat.
//   One result beat leaves on m_tvalid/m_tready per input beat, in order.
//   Configuration: write i_cfg_data to register i_cfg_idx (0 mode, 1 threshold)
//   while i_cfg_we is high; write only while the core is idle.
// Timing:
//   Hard mode and untouched degrees go through S_CLASSIFY and S_DONE to the result
//   register. Soft mode goes through the squares, the sum, 32 root digits, the
//   check and two 32-step divisions, with the multiplier and load steps around
//   them, all on the single compare-subtract unit. s_tready is high only while
//   the sequencer is idle, so one beat is in work at a time.
// Reset and stall:
//   Synchronous active-low reset clears mode, threshold, accumulators and the
//   output valid. A finished result waits in the output register; the core
//   takes the next input beat while it waits, and holds a later result in its
//   final state until the receiver frees the register.
module complex_coefficient_threshold_core #(
    parameter int MAX_DEGREE = cct_pkg::MAX_DEGREE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // degree [11:0], re_in [43:12], im_in [75:44], zero [79:76]
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [79:0]   s_tdata,
    // first [0]
    input  logic          s_tuser,
    // re_out [31:0], im_out [63:32], kept_count [87:64], max_kept_degree [99:88],
    // zero [103:100]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [30:0]   i_cfg_data
);

    localparam logic CFG_MODE      = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;
    localparam logic MODE_HARD     = 1'b0;
    localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE, S_CLASSIFY, S_SQ_RE, S_SQ_IM, S_SUM, S_SQRT, S_CHECK,
        S_MUL_RE, S_LD_RE, S_DIV_RE, S_MUL_IM, S_LD_IM, S_DIV_IM, S_STORE_IM, S_DONE
    } t_state;

    t_state         r_state;
    logic           r_mode;
    logic [30:0]    r_thr;
    logic [23:0]    r_count;
    logic [11:0]    r_maxdeg;

    // item in work
    logic           r_first;
    logic [11:0]    r_deg;
    logic [31:0]    r_re_raw;
    logic [31:0]    r_im_raw;

    // datapath
    logic [63:0]    r_prod;
    logic [63:0]    r_x;
    logic [33:0]    r_rem;
    logic [31:0]    r_q;
    logic [31:0]    r_m;
    logic [31:0]    r_k;
    logic [4:0]     r_step;
    logic [31:0]    r_re_res;
    logic [31:0]    r_im_res;
    logic [1:0]     r_add;
    logic           r_keep;

    // output register
    logic           r_m_valid;
    logic [31:0]    r_out_re;
    logic [31:0]    r_out_im;
    logic [23:0]    r_out_cnt;
    logic [11:0]    r_out_deg;

    logic [31:0]    w_re_mag;
    logic [31:0]    w_im_mag;
    logic           w_deg_ok;
    logic           w_re_keep;
    logic           w_im_keep;
    logic [31:0]    w_mul_a;
    logic [31:0]    w_mul_b;
    logic [63:0]    w_prod;
    logic [33:0]    w_cs_a;
    logic [33:0]    w_cs_b;
    cct_pkg::t_csub_res w_cs;
    logic [33:0]    w_rem_next;
    logic [31:0]    w_q_next;
    logic [23:0]    w_cnt_base;
    logic [11:0]    w_deg_base;
    logic [24:0]    w_cnt_sum;
    logic           w_out_free;

    function automatic logic [31:0] f_sign(input logic [31:0] mag, input logic neg);
        return neg ? (~mag + 32'd1) : mag;
    endfunction

    // magnitudes; -2^31 maps to 2^31, which still fits unsigned
    assign w_re_mag  = f_sign(r_re_raw, r_re_raw[31]);
    assign w_im_mag  = f_sign(r_im_raw, r_im_raw[31]);
    assign w_deg_ok  = (r_deg != 12'd0) && ({4'd0, r_deg} <= 16'(MAX_DEGREE));
    assign w_re_keep = ~(w_re_mag < {1'b0, r_thr});
    assign w_im_keep = ~(w_im_mag < {1'b0, r_thr});

    // shared multiplier: squares first, then part times (M - T)
    always_comb begin
        case (r_state)
            S_SQ_RE: begin
                w_mul_a = w_re_mag;
                w_mul_b = w_re_mag;
            end
            S_SQ_IM: begin
                w_mul_a = w_im_mag;
                w_mul_b = w_im_mag;
            end
            S_MUL_RE: begin
                w_mul_a = w_re_mag;
                w_mul_b = r_k;
            end
            default: begin
                w_mul_a = w_im_mag;
                w_mul_b = r_k;
            end
        endcase
    end

    assign w_prod = {32'd0, w_mul_a} * {32'd0, w_mul_b};

    // shared compare-subtract: root digit (two radicand bits in) or quotient bit
    always_comb begin
        if (r_state == S_SQRT) begin
            w_cs_a = {r_rem[31:0], r_x[63:62]};
            w_cs_b = {r_q, 2'b01};
        end else begin
            w_cs_a = {r_rem[32:0], r_x[63]};
            w_cs_b = {2'b00, r_m};
        end
    end

    cct_csub u_csub (
        .i_a   (w_cs_a),
        .i_b   (w_cs_b),
        .o_res (w_cs)
    );

    assign w_rem_next = w_cs.ge ? w_cs.diff : w_cs_a;
    assign w_q_next   = {r_q[30:0], w_cs.ge};

    // accumulators after the optional clear, then the saturating add
    assign w_cnt_base = r_first ? 24'd0 : r_count;
    assign w_deg_base = r_first ? 12'd0 : r_maxdeg;
    assign w_cnt_sum  = {1'b0, w_cnt_base} + {23'd0, r_add};
    assign w_out_free = ~r_m_valid | m_tready;

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = {4'd0, r_out_deg, r_out_cnt, r_out_im, r_out_re};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= MODE_HARD;
            r_thr     <= '0;
            r_count   <= '0;
            r_maxdeg  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:      r_mode <= i_cfg_data[0];
                    CFG_THRESHOLD: r_thr  <= i_cfg_data;
                    default:       ;
                endcase
            end

            // drop the result once the receiver takes it, unless a new one lands
            if (r_m_valid && m_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_first  <= s_tuser;
                        r_deg    <= s_tdata[11:0];
                        r_re_raw <= s_tdata[43:12];
                        r_im_raw <= s_tdata[75:44];
                        r_state  <= S_CLASSIFY;
                    end
                end
                S_CLASSIFY: begin
                    if (!w_deg_ok) begin
                        // pass through, not counted
                        r_re_res <= r_re_raw;
                        r_im_res <= r_im_raw;
                        r_add    <= 2'd0;
                        r_keep   <= 1'b0;
                        r_state  <= S_DONE;
                    end else if (r_mode == MODE_HARD) begin
                        r_re_res <= w_re_keep ? r_re_raw : 32'd0;
                        r_im_res <= w_im_keep ? r_im_raw : 32'd0;
                        r_add    <= {1'b0, w_re_keep} + {1'b0, w_im_keep};
                        r_keep   <= w_re_keep | w_im_keep;
                        r_state  <= S_DONE;
                    end else begin
                        r_state  <= S_SQ_RE;
                    end
                end
                S_SQ_RE: begin
                    r_prod  <= w_prod;
                    r_state <= S_SQ_IM;
                end
                S_SQ_IM: begin
                    r_prod  <= w_prod;
                    r_x     <= r_prod;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_x     <= r_x + r_prod;
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_step  <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_rem  <= w_rem_next;
                    r_q    <= w_q_next;
                    r_x    <= {r_x[61:0], 2'b00};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_q == 32'd0 || {1'b0, r_thr} > r_q) begin
                        r_re_res <= '0;
                        r_im_res <= '0;
                        r_add    <= 2'd0;
                        r_keep   <= 1'b0;
                        r_state  <= S_DONE;
                    end else begin
                        r_m     <= r_q;
                        r_k     <= r_q - {1'b0, r_thr};
                        r_add   <= 2'd1;
                        r_keep  <= 1'b1;
                        r_state <= S_MUL_RE;
                    end
                end
                S_MUL_RE: begin
                    r_prod  <= w_prod;
                    r_state <= S_LD_RE;
                end
                S_LD_RE, S_LD_IM: begin
                    // quotient fits 32 bits, so the high half is already below M
                    r_rem   <= {2'b00, r_prod[63:32]};
                    r_x     <= {r_prod[31:0], 32'd0};
                    r_q     <= '0;
                    r_step  <= '0;
                    r_state <= (r_state == S_LD_RE) ? S_DIV_RE : S_DIV_IM;
                end
                S_DIV_RE, S_DIV_IM: begin
                    r_rem  <= w_rem_next;
                    r_q    <= w_q_next;
                    r_x    <= {r_x[62:0], 1'b0};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_state <= (r_state == S_DIV_RE) ? S_MUL_IM : S_STORE_IM;
                    end
                end
                S_MUL_IM: begin
                    r_re_res <= f_sign(r_q, r_re_raw[31]);
                    r_prod   <= w_prod;
                    r_state  <= S_LD_IM;
                end
                S_STORE_IM: begin
                    r_im_res <= f_sign(r_q, r_im_raw[31]);
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_count   <= w_cnt_sum[24] ? COUNT_MAX : w_cnt_sum[23:0];
                        r_maxdeg  <= (r_keep && r_deg > w_deg_base) ? r_deg : w_deg_base;
                        r_out_re  <= r_re_res;
                        r_out_im  <= r_im_res;
                        r_out_cnt <= w_cnt_sum[24] ? COUNT_MAX : w_cnt_sum[23:0];
                        r_out_deg <= (r_keep && r_deg > w_deg_base) ? r_deg : w_deg_base;
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // one beat in work at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // a finished item lands in the output register and frees the input
    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && w_out_free |=> m_tvalid && s_tready)
        else $error("finished item did not reach the output register");

    // restoring division keeps the partial remainder below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_RE) || (r_state == S_DIV_IM) |-> r_rem < {2'b00, r_m})
        else $error("division remainder not below modulus");

    // root remainder never exceeds twice the partial root
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> r_rem <= {1'b0, r_q, 1'b0})
        else $error("square root remainder out of range");

endmodule

### design/cct_csub.sv
`timescale 1ns / 1ps
// Shared compare-subtract unit: one digit step of the square root and the divider.
// Depends on cct_pkg.
module cct_csub (
    input  logic [cct_pkg::W_REM-1:0] i_a,
    input  logic [cct_pkg::W_REM-1:0] i_b,
    output cct_pkg::t_csub_res        o_res
);

    logic [cct_pkg::W_REM:0] w_diff;

    // borrow out of the extended subtract means a < b
    assign w_diff     = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~w_diff[cct_pkg::W_REM];
    assign o_res.diff = w_diff[cct_pkg::W_REM-1:0];

endmodule
